// ===== hdl/rmyb_pkg.sv =====
// Shared types, constants and colour coefficients for the raster to MCU blocker.
// Used by every module of the block but rmyb_fifo; depends on nothing else.
package rmyb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_FACTOR_DEF = 2;
  localparam int BLOCK_SIZE     = 8;
  localparam int OUT_DEPTH      = 4;
  localparam int OPQ_DEPTH      = 2;

  // Fixed-point colour coefficients, 16 fraction bits.
  localparam logic [15:0] C_YR  = 16'd19595;
  localparam logic [15:0] C_YG  = 16'd38470;
  localparam logic [15:0] C_YB  = 16'd7471;
  localparam logic [15:0] C_CBR = 16'd11056;
  localparam logic [15:0] C_CBG = 16'd21712;
  localparam logic [15:0] C_HALF = 16'd32768;
  localparam logic [15:0] C_CRG = 16'd27440;
  localparam logic [15:0] C_CRB = 16'd5328;
  localparam logic [25:0] C_OFS = 26'd8388608;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_WIDE   = 3'd2,
    REG_TALL   = 3'd3,
    REG_GRAY   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_REFUSE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_PULL   = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       last_of_mcu;
    logic       last_of_image;
  } out_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_mcu;
    logic       last_img;
  } op_t;

endpackage

// ===== hdl/rmyb_fifo.sv =====
// Small register queue with a combinational head, used for the operation queue
// and the result queue. Depends on nothing; the writer never overfills it.
module rmyb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [W-1:0]                 wr_data,
  input  logic                         rd_en,
  output logic [W-1:0]                 rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign rd_data = mem_r[rp_r];
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end
endmodule

// ===== hdl/rmyb_front.sv =====
// Front end: configuration registers, stream position counters and the
// classification of each transaction into push, pull or refusal. Uses rmyb_pkg.
module rmyb_front #(
  parameter int MAX_WIDTH  = rmyb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = rmyb_pkg::MAX_FACTOR_DEF,
  parameter int AW         = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 item_valid,
  input  rmyb_pkg::in_t        item,
  output logic                 op_valid,
  output rmyb_pkg::op_t        op,
  output logic [AW-1:0]        op_addr,
  output logic                 gray
);
  import rmyb_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int ROWS = BLOCK_SIZE * MAX_FACTOR;
  localparam int YW   = $clog2(ROWS);
  localparam int HW   = $clog2(ROWS + 1);
  localparam int WW   = (XW + 1 > 12) ? XW + 1 : 12;
  localparam int BW   = WW + 1;

  logic [11:0]   width_r;
  logic [15:0]   height_r;
  logic [1:0]    wide_r, tall_r;
  logic          gray_r;

  logic [YW-1:0] push_row_r, push_row_nxt;
  logic [XW-1:0] push_col_r, push_col_nxt;
  logic          ready_r, ready_nxt;
  logic [HW-1:0] valid_rows_r, valid_rows_nxt;
  logic [15:0]   row_base_r, row_base_nxt;
  logic [BW-1:0] x_base_r, x_base_nxt;
  logic [YW-1:0] in_row_r, in_row_nxt;
  logic [YW-1:0] in_col_r, in_col_nxt;

  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [1:0]    fw, ft;
  logic [HW-1:0] mw, mh;
  logic [15:0]   left;
  logic [HW-1:0] need;
  logic [BW-1:0] xs;
  logic [HW-1:0] ys;
  logic [16:0]   next_base;
  logic          row_end, mcu_end, strip_end;

  assign gray = gray_r;

  always_comb begin
    eff_w = WW'(width_r);
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (WW'(width_r) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end
    eff_h = (height_r == '0) ? 16'd1 : height_r;
    fw = (wide_r == '0) ? 2'd1 : ((32'(wide_r) > MAX_FACTOR) ? 2'(MAX_FACTOR) : wide_r);
    ft = (tall_r == '0) ? 2'd1 : ((32'(tall_r) > MAX_FACTOR) ? 2'(MAX_FACTOR) : tall_r);
    mw = gray_r ? HW'(BLOCK_SIZE) : HW'(HW'(fw) * HW'(BLOCK_SIZE));
    mh = gray_r ? HW'(BLOCK_SIZE) : HW'(HW'(ft) * HW'(BLOCK_SIZE));
    left = (eff_h > row_base_r) ? eff_h - row_base_r : 16'd1;
    need = (left < 16'(mh)) ? HW'(left) : mh;
  end

  always_comb begin
    push_row_nxt   = push_row_r;
    push_col_nxt   = push_col_r;
    ready_nxt      = ready_r;
    valid_rows_nxt = valid_rows_r;
    row_base_nxt   = row_base_r;
    x_base_nxt     = x_base_r;
    in_row_nxt     = in_row_r;
    in_col_nxt     = in_col_r;
    op             = '0;
    op.kind        = OP_REFUSE;
    op.red         = item.red;
    op.green       = item.green;
    op.blue        = item.blue;
    op_addr        = '0;
    op_valid       = item_valid;
    row_end        = 1'b0;
    mcu_end        = 1'b0;
    strip_end      = 1'b0;
    next_base      = 17'(row_base_r) + 17'(mh);

    xs = x_base_r + BW'(in_col_r);
    if (xs > BW'(eff_w - 1'b1)) begin
      xs = BW'(eff_w - 1'b1);
    end
    if (valid_rows_r == '0) begin
      ys = '0;
    end else if (HW'(in_row_r) > valid_rows_r - 1'b1) begin
      ys = valid_rows_r - 1'b1;
    end else begin
      ys = HW'(in_row_r);
    end

    if (cfg_we) begin
      op_valid       = 1'b0;
      push_row_nxt   = '0;
      push_col_nxt   = '0;
      ready_nxt      = 1'b0;
      valid_rows_nxt = '0;
      row_base_nxt   = '0;
      x_base_nxt     = '0;
      in_row_nxt     = '0;
      in_col_nxt     = '0;
    end else if (item_valid && !item.func) begin
      if (!ready_r) begin
        op.kind = OP_PUSH;
        op_addr = {push_row_r, push_col_r};
        if (WW'(push_col_r) + 1'b1 >= eff_w) begin
          push_col_nxt = '0;
          push_row_nxt = push_row_r + 1'b1;
          if (HW'(push_row_r) + 1'b1 >= need) begin
            ready_nxt      = 1'b1;
            valid_rows_nxt = need;
            push_row_nxt   = '0;
            x_base_nxt     = '0;
            in_row_nxt     = '0;
            in_col_nxt     = '0;
          end
        end else begin
          push_col_nxt = push_col_r + 1'b1;
        end
      end
    end else if (item_valid) begin
      if (ready_r) begin
        op.kind = OP_PULL;
        op_addr = {ys[YW-1:0], xs[XW-1:0]};
        row_end = (HW'(in_col_r) + 1'b1 >= mw);
        mcu_end = row_end && (HW'(in_row_r) + 1'b1 >= mh);
        strip_end = mcu_end && (x_base_r + BW'(mw) >= BW'(eff_w));
        in_col_nxt = row_end ? '0 : in_col_r + 1'b1;
        if (row_end) begin
          in_row_nxt = mcu_end ? '0 : in_row_r + 1'b1;
        end
        if (mcu_end) begin
          op.last_mcu = 1'b1;
          x_base_nxt  = x_base_r + BW'(mw);
        end
        if (strip_end) begin
          x_base_nxt     = '0;
          ready_nxt      = 1'b0;
          valid_rows_nxt = '0;
          if (next_base >= 17'(eff_h)) begin
            op.last_img  = 1'b1;
            row_base_nxt = '0;
          end else begin
            row_base_nxt = next_base[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= 12'd8;
      height_r     <= 16'd8;
      wide_r       <= 2'd1;
      tall_r       <= 2'd1;
      gray_r       <= 1'b0;
      push_row_r   <= '0;
      push_col_r   <= '0;
      ready_r      <= 1'b0;
      valid_rows_r <= '0;
      row_base_r   <= '0;
      x_base_r     <= '0;
      in_row_r     <= '0;
      in_col_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data[11:0];
          REG_HEIGHT: height_r <= cfg_data;
          REG_WIDE:   wide_r   <= cfg_data[1:0];
          REG_TALL:   tall_r   <= cfg_data[1:0];
          REG_GRAY:   gray_r   <= cfg_data[0];
          default: ;
        endcase
      end
      // An unknown index leaves the stream position alone.
      if (!cfg_we || cfg_index <= REG_GRAY) begin
        push_row_r   <= push_row_nxt;
        push_col_r   <= push_col_nxt;
        ready_r      <= ready_nxt;
        valid_rows_r <= valid_rows_nxt;
        row_base_r   <= row_base_nxt;
        x_base_r     <= x_base_nxt;
        in_row_r     <= in_row_nxt;
        in_col_r     <= in_col_nxt;
      end
    end
  end
endmodule

// ===== hdl/rmyb_back.sv =====
// Back end: colour conversion pipeline, strip memory and result formatting,
// feeding the result queue through a credit count. Uses rmyb_pkg and rmyb_fifo.
module rmyb_back #(
  parameter int AW = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               gray,
  input  logic               q_empty,
  input  rmyb_pkg::op_t      q_op,
  input  logic [AW-1:0]      q_addr,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rmyb_pkg::out_t     out_data
);
  import rmyb_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [23:0]   mem [2**AW];

  logic          va_r, vb_r, vc_r;
  op_t           opa_r, opb_r, opc_r;
  logic [AW-1:0] adda_r, addb_r;
  logic [23:0]   p_yr_r, p_yg_r, p_yb_r;
  logic [23:0]   p_cbr_r, p_cbg_r, p_cbb_r;
  logic [23:0]   p_crr_r, p_crg_r, p_crb_r;
  logic [23:0]   wdata_r;
  logic [23:0]   rdata_r;
  logic [23:0]   conv;
  logic [25:0]   sy, scb, scr;
  logic [OCW-1:0] ocount;
  logic [OCW:0]  total;
  logic          ofull;
  logic          pop_ok;
  out_t          res;

  always_comb begin
    total  = (OCW+1)'(ocount) + (OCW+1)'(va_r) + (OCW+1)'(vb_r) + (OCW+1)'(vc_r);
    pop_ok = (total < (OCW+1)'(OUT_DEPTH)) || (out_pop && !out_empty);
    q_pop  = !q_empty && pop_ok;
  end

  // Stage B sums, truncated to the integer part.
  always_comb begin
    sy  = 26'(p_yr_r) + 26'(p_yg_r) + 26'(p_yb_r);
    scb = C_OFS + 26'(p_cbb_r) - 26'(p_cbr_r) - 26'(p_cbg_r);
    scr = C_OFS + 26'(p_crr_r) - 26'(p_crg_r) - 26'(p_crb_r);
    if (gray) begin
      conv = {opb_r.red, 16'd0};
    end else begin
      conv = {sy[23:16], scb[23:16], scr[23:16]};
    end
  end

  // The products are formed from stage A so that they sit beside their
  // transaction in stage B.
  always_ff @(posedge clk) begin
    opa_r   <= q_op;
    adda_r  <= q_addr;
    p_yr_r  <= opa_r.red   * C_YR;
    p_yg_r  <= opa_r.green * C_YG;
    p_yb_r  <= opa_r.blue  * C_YB;
    p_cbr_r <= opa_r.red   * C_CBR;
    p_cbg_r <= opa_r.green * C_CBG;
    p_cbb_r <= opa_r.blue  * C_HALF;
    p_crr_r <= opa_r.red   * C_HALF;
    p_crg_r <= opa_r.green * C_CRG;
    p_crb_r <= opa_r.blue  * C_CRB;
    opb_r   <= opa_r;
    addb_r  <= adda_r;
    opc_r   <= opb_r;
    wdata_r <= conv;
    if (vb_r && opb_r.kind == OP_PUSH) begin
      mem[addb_r] <= conv;
    end
    if (vb_r && opb_r.kind == OP_PULL) begin
      rdata_r <= mem[addb_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= q_pop;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_comb begin
    res = '0;
    case (opc_r.kind)
      OP_PUSH: res.accepted = 1'b1;
      OP_PULL: begin
        res.accepted      = 1'b1;
        res.luma          = rdata_r[23:16];
        res.chroma_blue   = gray ? 8'd0 : rdata_r[15:8];
        res.chroma_red    = gray ? 8'd0 : rdata_r[7:0];
        res.last_of_mcu   = opc_r.last_mcu;
        res.last_of_image = opc_r.last_img;
      end
      default: res = '0;
    endcase
  end

  rmyb_fifo #(.W($bits(out_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (vc_r),
    .wr_data (res),
    .rd_en   (out_pop && !out_empty),
    .rd_data (out_data),
    .full    (ofull),
    .empty   (out_empty),
    .count   (ocount)
  );

  // The credit count keeps the result queue from overfilling; the queue is never
  // written while it is full.
  logic unused_ok;
  assign unused_ok = ofull & (wdata_r == '0);
endmodule

// ===== hdl/raster_to_mcu_ycbcr_blocker_core.sv =====
// Raster to MCU blocker with RGB to YCbCr conversion, top level.
// Throughput: one transaction per cycle on the input and on the output, while the
// output side keeps popping results. Path: an accepted transaction passes through
// the operation queue, the two conversion stages, the memory read stage and the result queue.
// Reset: synchronous active low; the control registers return to their defaults,
// while the pipeline data and the strip memory are not cleared and need no clearing pass.
module raster_to_mcu_ycbcr_blocker_core #(
  parameter int MAX_WIDTH  = rmyb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = rmyb_pkg::MAX_FACTOR_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  rmyb_pkg::in_t   in_data,
  output logic            out_empty,
  input  logic            out_pop,
  output rmyb_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import rmyb_pkg::*;

  localparam int AW = $clog2(BLOCK_SIZE * MAX_FACTOR) + $clog2(MAX_WIDTH);
  localparam int QW = AW + $bits(op_t);

  logic          f_valid;
  op_t           f_op;
  logic [AW-1:0] f_addr;
  logic          gray;
  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_head;
  logic [$clog2(OPQ_DEPTH+1)-1:0] q_count;
  logic          q_unused;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign q_unused  = |q_count;

  rmyb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_FACTOR(MAX_FACTOR), .AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (in_push && !q_full),
    .item       (in_data),
    .op_valid   (f_valid),
    .op         (f_op),
    .op_addr    (f_addr),
    .gray       (gray)
  );

  rmyb_fifo #(.W(QW), .DEPTH(OPQ_DEPTH)) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_data ({f_addr, f_op}),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_count)
  );

  rmyb_back #(.AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gray      (gray),
    .q_empty   (q_empty),
    .q_op      (q_head[$bits(op_t)-1:0]),
    .q_addr    (q_head[QW-1:$bits(op_t)]),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );
endmodule

// ===== dv/raster_to_mcu_ycbcr_blocker_core_tb.sv =====
// Self-checking testbench for the raster to MCU blocker with colour conversion.
// Depends on rmyb_pkg and raster_to_mcu_ycbcr_blocker_core; pixels and samples are
// predicted by an in-bench model of the strip and checked in order of arrival.
module raster_to_mcu_ycbcr_blocker_core_tb;
  import rmyb_pkg::*;

  localparam int          STORE_ROWS = BLOCK_SIZE * MAX_FACTOR_DEF;
  localparam logic [2:0]  REG_SPARE  = 3'd7;
  localparam logic        FN_PUSH    = 1'b0;
  localparam logic        FN_PULL    = 1'b1;
  localparam int          CYCLE_CAP  = 2000000;
  localparam int          SETTLE     = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_t         in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  raster_to_mcu_ycbcr_blocker_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the block's registers and stream position.
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [1:0]  wide_r, tall_r;
  logic        gray_r;
  logic [23:0] strip_mem [STORE_ROWS * MAX_WIDTH_DEF];
  int unsigned fill_row, fill_col, rows_kept, row_base, mcu_col, in_row, in_col;
  bit          strip_full;

  out_t        sample_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          samples_seen = 0;
  int          images_done = 0;
  int          cycles = 0;
  bit          rx_hold = 1'b0;
  bit          no_gaps = 1'b0;

  function automatic int unsigned factor(logic [1:0] f);
    return (f == 0) ? 1 : (f > MAX_FACTOR_DEF) ? MAX_FACTOR_DEF : f;
  endfunction

  function automatic void clear_position();
    fill_row = 0; fill_col = 0; strip_full = 0; rows_kept = 0;
    row_base = 0; mcu_col = 0; in_row = 0; in_col = 0;
  endfunction

  function automatic logic [23:0] to_ycbcr(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned y, cb, cr;
    if (gray_r) return {r, 16'h0};
    y  = (19595 * r + 38470 * g + 7471 * b) >> 16;
    cb = (8388608 + 32768 * b - 11056 * r - 21712 * g) >> 16;
    cr = (8388608 + 32768 * r - 27440 * g - 5328 * b) >> 16;
    return {y[7:0], cb[7:0], cr[7:0]};
  endfunction

  // Works out the result of one accepted transaction and advances the mirror.
  function automatic out_t next_sample(in_t it);
    int unsigned w, h, mw, mh, need, ncols, x, y;
    logic [23:0] v;
    out_t o;
    o = '0;
    w  = (width_r == 0) ? 1 : (width_r > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_r;
    h  = (height_r == 0) ? 1 : height_r;
    mw = gray_r ? BLOCK_SIZE : BLOCK_SIZE * factor(wide_r);
    mh = gray_r ? BLOCK_SIZE : BLOCK_SIZE * factor(tall_r);
    if (it.func == FN_PUSH) begin
      if (strip_full) return o;
      if (fill_row >= STORE_ROWS) fill_row = 0;
      if (fill_col >= w) fill_col = 0;
      strip_mem[fill_row * MAX_WIDTH_DEF + fill_col] = to_ycbcr(it.red, it.green, it.blue);
      o.accepted = 1'b1;
      fill_col++;
      if (fill_col >= w) begin
        need = (h > row_base) ? h - row_base : 1;
        if (need > mh) need = mh;
        fill_col = 0;
        fill_row++;
        if (fill_row >= need) begin
          strip_full = 1; rows_kept = need; fill_row = 0;
          mcu_col = 0; in_row = 0; in_col = 0;
        end
      end
    end else begin
      if (!strip_full) return o;
      ncols = (w + mw - 1) / mw;
      if (mcu_col >= ncols) mcu_col = 0;
      if (in_row >= mh) in_row = 0;
      if (in_col >= mw) in_col = 0;
      x = mcu_col * mw + in_col;
      if (x > w - 1) x = w - 1;
      y = (rows_kept == 0) ? 0 : (in_row > rows_kept - 1) ? rows_kept - 1 : in_row;
      v = strip_mem[y * MAX_WIDTH_DEF + x];
      o.accepted    = 1'b1;
      o.luma        = v[23:16];
      o.chroma_blue = gray_r ? 8'h0 : v[15:8];
      o.chroma_red  = gray_r ? 8'h0 : v[7:0];
      in_col++;
      if (in_col >= mw) begin
        in_col = 0;
        in_row++;
        if (in_row >= mh) begin
          in_row = 0;
          o.last_of_mcu = 1'b1;
          mcu_col++;
          if (mcu_col >= ncols) begin
            mcu_col = 0; strip_full = 0; rows_kept = 0;
            if (row_base + mh >= h) begin
              o.last_of_image = 1'b1;
              row_base = 0;
            end else begin
              row_base = (row_base + mh) & 16'hFFFF;
            end
          end
        end
      end
    end
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at sample %0d: %s got %0d expected %0d", samples_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    out_pop <= rx_hold ? 1'b0 : (no_gaps ? 1'b1 : ($urandom_range(99) >= 31));

  // Checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && !out_empty && out_pop) begin
      if (sample_q.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        want = sample_q.pop_front();
        if (out_data.accepted != want.accepted) report("accepted", out_data.accepted, want.accepted);
        if (out_data.luma != want.luma) report("luma", out_data.luma, want.luma);
        if (out_data.chroma_blue != want.chroma_blue)
          report("chroma_blue", out_data.chroma_blue, want.chroma_blue);
        if (out_data.chroma_red != want.chroma_red)
          report("chroma_red", out_data.chroma_red, want.chroma_red);
        if (out_data.last_of_mcu != want.last_of_mcu)
          report("last_of_mcu", out_data.last_of_mcu, want.last_of_mcu);
        if (out_data.last_of_image != want.last_of_image)
          report("last_of_image", out_data.last_of_image, want.last_of_image);
        if (want.last_of_image) images_done++;
      end
      samples_seen++;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!no_gaps && $urandom_range(99) < 31) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_push = 1'b1;
    in_data = '{func: fn, red: r, green: g, blue: b};
    do @(posedge clk); while (in_full);
    sample_q.push_back(next_sample(in_data));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_push = 1'b0;
    wait (sample_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  width_r  = val[11:0];
      REG_HEIGHT: height_r = val;
      REG_WIDE:   wide_r   = val[1:0];
      REG_TALL:   tall_r   = val[1:0];
      REG_GRAY:   gray_r   = val[0];
      default: ;
    endcase
    if (idx <= REG_GRAY) clear_position();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_shape(int w, int h, int wd, int tl, bit gr);
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_WIDE, 16'(wd));
    write_reg(REG_TALL, 16'(tl));
    write_reg(REG_GRAY, 16'(gr));
  endtask

  task automatic push_pixel();
    send_item(FN_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic pull_sample();
    send_item(FN_PULL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Mostly well-formed: fill the strip, then read it out, with a little noise.
  task automatic run_stream(int count);
    bit wrong;
    repeat (count) begin
      wrong = ($urandom_range(99) < 6);
      if (strip_full ^ wrong) pull_sample();
      else push_pixel();
    end
  endtask

  task automatic test_directed();
    send_item(FN_PULL, 8'hFF, 8'hFF, 8'hFF);
    set_shape(1, 2, 3, 0, 0);
    send_item(FN_PUSH, 8'h00, 8'h00, 8'h00);
    send_item(FN_PUSH, 8'hFF, 8'hFF, 8'hFF);
    send_item(FN_PUSH, 8'hFF, 8'h00, 8'h00);
    repeat (128) pull_sample();
    set_shape(2, 1, 1, 1, 1);
    send_item(FN_PUSH, 8'hFF, 8'h00, 8'hFF);
    send_item(FN_PUSH, 8'h00, 8'hFF, 8'h00);
    repeat (64) pull_sample();
    send_item(FN_PUSH, 8'h00, 8'hFF, 8'h00);
    send_item(FN_PUSH, 8'hFF, 8'h00, 8'hFF);
    write_reg(REG_SPARE, 16'hFFFF);
    push_pixel();
    set_shape(0, 0, 2, 2, 0);
    send_item(FN_PUSH, 8'h00, 8'hFF, 8'hFF);
    repeat (256) pull_sample();
  endtask

  // An oversized width saturates, so a long partial row is still taken in
  // and pulls stay refused.
  task automatic test_widest();
    set_shape(12'hFFF, 1, 1, 1, 1);
    repeat (300) push_pixel();
    repeat (8) pull_sample();
  endtask

  task automatic test_back_pressure();
    set_shape(40, 16, 1, 2, 0);
    rx_hold = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    run_stream(120);
    drain();
    run_stream(60);
  endtask

  task automatic test_random();
    no_gaps = 1'b1;
    set_shape(17, 9, 2, 1, 0);
    run_stream(300);
    no_gaps = 1'b0;
    set_shape(3, 16'hFFFF, 0, 3, 0);
    run_stream(100);
    repeat (6) begin
      set_shape($urandom_range(1, 24), $urandom_range(1, 40), $urandom_range(0, 3),
                $urandom_range(0, 3), $urandom_range(0, 1));
      run_stream(100);
    end
  endtask

  initial begin
    width_r = 8; height_r = 8; wide_r = 1; tall_r = 1; gray_r = 0;
    clear_position();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_widest();
    test_back_pressure();
    test_random();
    drain();
    $display("%0d transactions sent, %0d results checked, %0d images completed",
             items_sent, samples_seen, images_done);
    $display("covered refusals, saturating registers, edge replication, both modes");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rmyb_pkg.sv
hdl/rmyb_fifo.sv
hdl/rmyb_front.sv
hdl/rmyb_back.sv
hdl/raster_to_mcu_ycbcr_blocker_core.sv
dv/raster_to_mcu_ycbcr_blocker_core_tb.sv
